@@ hw/rtl/reol_pkg.sv @@
// Shared types and constants for the ring entry offset locator.
// No dependencies; imported by reol_ram users and the top level.
package reol_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // running sum of up to DEPTH 16-bit sizes, plus one size of headroom
  localparam int unsigned SUM_W = 16 + IDX_W + 1;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_FIND = 2'd1,
    OP_SEEK = 2'd2
  } op_e;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] size;
  } entry_t;

  // ring pointer increment, wraps at DEPTH
  function automatic idx_t wrap_inc(idx_t a);
    return (32'(a) == DEPTH - 1) ? '0 : a + idx_t'(1);
  endfunction

endpackage

@@ hw/rtl/ring_entry_offset_locator.sv @@
// Ring entry offset locator: overwriting ring of entries with byte lookup.
// Flow: an add reads the tail, then writes the new entry; find/seek walk the stored
//   entries from the head in the one-entry-per-cycle RAM read walk.
//   One word at a time; the next word is accepted once its result is loaded into
//   the output register, which waits while a held result is not taken by out_ready_i.
// Reset: ring empty, total 0, no word pending. Depends on reol_pkg and reol_ram.
module ring_entry_offset_locator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] new_handle_i,
  input  logic [15:0] new_size_i,
  input  logic [19:0] byte_position_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] offset_in_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [3:0]  slot_o,
  output logic [31:0] found_handle_o,
  output logic [15:0] byte_in_entry_o,
  output logic [19:0] absolute_offset_o,
  output logic [4:0]  entry_count_o,
  output logic [19:0] total_length_o
);
  import reol_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,   // read of the tail entry is back; write new entry
    ST_WALK,  // one stored entry examined per cycle
    ST_DONE   // hand the result to the output register
  } state_e;

  state_e state_q;

  // ring bookkeeping
  idx_t              head_q, tail_q;
  logic              full_q;
  logic [19:0]       total_q;

  // captured word
  op_e               op_q;
  logic [31:0]       handle_q;
  logic [15:0]       size_q;
  logic [19:0]       pos_q;
  logic [7:0]        idx_q;
  logic [15:0]       off_q;

  // walk
  idx_t              rd_ptr_q;   // slot of the entry whose data is on ram_rdata
  logic [CNT_W-1:0]  k_q;        // entries examined so far
  logic [SUM_W-1:0]  sum_q;      // sizes of the entries passed

  // pending result
  logic              res_hit_q;
  logic [3:0]        res_slot_q;
  logic [31:0]       res_handle_q;
  logic [15:0]       res_bie_q;
  logic [19:0]       res_abs_q;

  // output register
  logic              out_valid_q;
  logic              hit_q;
  logic [3:0]        slot_q;
  logic [31:0]       found_handle_q;
  logic [15:0]       bie_q;
  logic [19:0]       abs_q;
  logic [4:0]        count_q;
  logic [19:0]       total_out_q;

  // RAM
  logic              ram_we;
  idx_t              ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic              accept;
  logic [CNT_W-1:0]  cnt;
  idx_t              rd_ptr_nxt, tail_nxt, head_nxt;
  logic [SUM_W-1:0]  acc;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // held entries
  always_comb begin
    if (full_q) begin
      cnt = CNT_W'(DEPTH);
    end else if (tail_q >= head_q) begin
      cnt = CNT_W'(tail_q - head_q);
    end else begin
      cnt = CNT_W'(DEPTH + 32'(tail_q) - 32'(head_q));
    end
  end

  assign rd_ptr_nxt = wrap_inc(rd_ptr_q);
  assign tail_nxt   = wrap_inc(tail_q);
  assign head_nxt   = full_q ? wrap_inc(head_q) : head_q;
  assign acc        = sum_q + SUM_W'(ram_rdata.size);

  // Read address: at accept an add fetches the tail (the oldest entry when
  // full), find/seek fetch the head; during the walk the next slot is
  // prefetched so one entry is examined each cycle.
  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_raddr = (op_e'(op_i) == OP_ADD) ? tail_q : head_q;
    end else begin
      ram_raddr = rd_ptr_nxt;
    end
  end

  assign ram_we           = (state_q == ST_ADD);
  assign ram_wdata.handle = handle_q;
  assign ram_wdata.size   = size_q;

  reol_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      head_q         <= '0;
      tail_q         <= '0;
      full_q         <= 1'b0;
      total_q        <= '0;
      op_q           <= OP_ADD;
      handle_q       <= '0;
      size_q         <= '0;
      pos_q          <= '0;
      idx_q          <= '0;
      off_q          <= '0;
      rd_ptr_q       <= '0;
      k_q            <= '0;
      sum_q          <= '0;
      res_hit_q      <= 1'b0;
      res_slot_q     <= '0;
      res_handle_q   <= '0;
      res_bie_q      <= '0;
      res_abs_q      <= '0;
      out_valid_q    <= 1'b0;
      hit_q          <= 1'b0;
      slot_q         <= '0;
      found_handle_q <= '0;
      bie_q          <= '0;
      abs_q          <= '0;
      count_q        <= '0;
      total_out_q    <= '0;
    end else begin
      // in ST_DONE the output register is handled by the done arm below
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q         <= op_e'(op_i);
            handle_q     <= new_handle_i;
            size_q       <= new_size_i;
            pos_q        <= byte_position_i;
            idx_q        <= entry_index_i;
            off_q        <= offset_in_entry_i;
            rd_ptr_q     <= head_q;
            k_q          <= '0;
            sum_q        <= '0;
            res_hit_q    <= 1'b0;
            res_slot_q   <= '0;
            res_handle_q <= '0;
            res_bie_q    <= '0;
            res_abs_q    <= '0;
            unique case (op_e'(op_i))
              OP_ADD:  state_q <= ST_ADD;
              OP_FIND: state_q <= ST_WALK;
              OP_SEEK: state_q <= ST_WALK;
              default: state_q <= ST_DONE;  // unused op: straight to done, no hit
            endcase
          end
        end

        ST_ADD: begin
          // overwriting the oldest entry drops its size from the total
          total_q <= total_q + 20'(size_q)
                     - (full_q ? 20'(ram_rdata.size) : 20'd0);
          head_q  <= head_nxt;
          tail_q  <= tail_nxt;
          full_q  <= (tail_nxt == head_nxt);
          state_q <= ST_DONE;
        end

        ST_WALK: begin
          rd_ptr_q <= rd_ptr_nxt;
          if (op_q == OP_FIND) begin
            if (32'(k_q) >= 32'(cnt)) begin
              state_q <= ST_DONE;               // position beyond the total
            end else if (acc > SUM_W'(pos_q)) begin
              res_hit_q    <= 1'b1;
              res_slot_q   <= 4'(rd_ptr_q);
              res_handle_q <= ram_rdata.handle;
              res_bie_q    <= 16'(SUM_W'(pos_q) - sum_q);
              state_q      <= ST_DONE;
            end else begin
              sum_q <= acc;
              k_q   <= k_q + CNT_W'(1);
            end
          end else begin
            if (32'(idx_q) >= 32'(cnt)) begin
              state_q <= ST_DONE;               // index past the newest entry
            end else if (32'(k_q) == 32'(idx_q)) begin
              if (off_q <= ram_rdata.size) begin
                res_hit_q <= 1'b1;
                res_abs_q <= 20'(sum_q + SUM_W'(off_q));
              end
              state_q <= ST_DONE;
            end else begin
              sum_q <= acc;
              k_q   <= k_q + CNT_W'(1);
            end
          end
        end

        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            hit_q          <= res_hit_q;
            slot_q         <= res_slot_q;
            found_handle_q <= res_handle_q;
            bie_q          <= res_bie_q;
            abs_q          <= res_abs_q;
            count_q        <= 5'(cnt);
            total_out_q    <= total_q;
            state_q        <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = hit_q;
  assign slot_o            = slot_q;
  assign found_handle_o    = found_handle_q;
  assign byte_in_entry_o   = bie_q;
  assign absolute_offset_o = abs_q;
  assign entry_count_o     = count_q;
  assign total_length_o    = total_out_q;

  // a full ring has head and tail on the same slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (head_q == tail_q))
    else $error("ring full with head and tail apart");

  // the walk never examines more than the ring holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (32'(k_q) <= DEPTH))
    else $error("walk ran past the ring");

  // an accepted word keeps the input side closed until its result is made
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input reopened right after accept");

endmodule

@@ hw/rtl/reol_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module reol_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
